@@ sv/usv_pkg.sv @@
// Shared types, codes and constants of the strict UTF-8 string validator.
package usv_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_STRING_BYTES = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUDGET_TOTAL = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REJECT_EMPTY = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REJECT_NUL = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REJECT_CONTROL = 3'd4;

    localparam logic [15:0] RESET_MAX_STRING_BYTES = 16'd8192;
    localparam logic [15:0] RESET_BUDGET_TOTAL = 16'd32768;

    typedef enum logic [2:0] {
        RULE_NORMAL = 3'd0,
        RULE_E0 = 3'd1,
        RULE_ED = 3'd2,
        RULE_F0 = 3'd3,
        RULE_F4 = 3'd4
    } rule_t;

    typedef enum logic [2:0] {
        ERR_NONE = 3'd0,
        ERR_ENCODING = 3'd1,
        ERR_TRUNCATED = 3'd2,
        ERR_FORBIDDEN = 3'd3,
        ERR_TOO_LONG = 3'd4,
        ERR_EMPTY = 3'd5,
        ERR_BUDGET = 3'd6
    } err_t;

    typedef struct packed {
        logic [15:0] max_bytes;
        logic [15:0] budget;
        logic        rej_empty;
        logic        rej_nul;
        logic        rej_ctrl;
    } cfg_t;

    // One request after classification of its byte.
    typedef struct packed {
        logic  forbidden;
        logic  ascii;
        logic  lead2;
        logic  lead3;
        logic  lead4;
        rule_t lead_rule;
        logic  cont_normal;
        logic  cont_e0;
        logic  cont_ed;
        logic  cont_f0;
        logic  cont_f4;
        logic  eos;
        logic  empty_item;
        logic  clear_budget;
    } class_t;

    typedef struct packed {
        logic        ok;
        err_t        code;
        logic [15:0] length;
        logic [15:0] budget_used;
    } result_t;

endpackage

@@ sv/usv_queue.sv @@
// Small first-in first-out queue of fixed-width words.
module usv_queue
    import usv_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/usv_front.sv @@
// Front end: classifies each incoming byte for the decoder.
module usv_front
    import usv_pkg::*;
(
    input  logic       rej_nul,
    input  logic       rej_ctrl,
    input  logic [7:0] data_byte,
    input  logic       end_of_string,
    input  logic       empty_string,
    input  logic       clear_budget,
    output class_t     cls
);

    always_comb
    begin
        cls.forbidden = (rej_nul && (data_byte == 8'h00))
                     || (rej_ctrl && ((data_byte < 8'h20) || (data_byte == 8'h7F)));
        cls.ascii = (data_byte <= 8'h7F);
        cls.lead2 = (data_byte inside {[8'hC2 : 8'hDF]});
        cls.lead3 = (data_byte inside {[8'hE0 : 8'hEF]});
        cls.lead4 = (data_byte inside {[8'hF0 : 8'hF4]});
        case (data_byte)
            8'hE0:   cls.lead_rule = RULE_E0;
            8'hED:   cls.lead_rule = RULE_ED;
            8'hF0:   cls.lead_rule = RULE_F0;
            8'hF4:   cls.lead_rule = RULE_F4;
            default: cls.lead_rule = RULE_NORMAL;
        endcase
        cls.cont_normal = (data_byte inside {[8'h80 : 8'hBF]});
        cls.cont_e0 = (data_byte inside {[8'hA0 : 8'hBF]});
        cls.cont_ed = (data_byte inside {[8'h80 : 8'h9F]});
        cls.cont_f0 = (data_byte inside {[8'h90 : 8'hBF]});
        cls.cont_f4 = (data_byte inside {[8'h80 : 8'h8F]});
        cls.eos = end_of_string;
        cls.empty_item = empty_string;
        cls.clear_budget = clear_budget;
    end

endmodule

@@ sv/usv_back.sv @@
// Back end: string state, UTF-8 sequence decoding, verdict and byte budget.
module usv_back
    import usv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  class_t  cls,
    input  logic    in_empty,
    output logic    in_pop,
    input  logic    out_full,
    output logic    out_push,
    output result_t result
);

    localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    logic [1:0]             pend_reg, pend_next;
    rule_t                  rule_reg, rule_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    err_t                   ferr_reg, ferr_next;
    logic [15:0]            used_reg, used_next;

    always_comb
    begin
        logic        ends;
        logic        active;
        logic        cok;
        logic        bad;
        err_t        byte_err;
        err_t        code;
        logic [15:0] ut0;
        logic [CW:0] sum;
        logic [CW-1:0] cnt_w;

        pend_next = pend_reg;
        rule_next = rule_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        ferr_next = ferr_reg;
        used_next = used_reg;
        bad = 1'b0;
        byte_err = ERR_NONE;
        code = ERR_NONE;
        sum = '0;
        cnt_w = '0;

        ends = cls.empty_item || cls.eos;
        active = !in_empty && (!ends || !out_full);
        in_pop = active;
        out_push = active && ends;
        ut0 = cls.clear_budget ? 16'd0 : used_reg;

        case (rule_reg)
            RULE_E0: cok = cls.cont_e0;
            RULE_ED: cok = cls.cont_ed;
            RULE_F0: cok = cls.cont_f0;
            RULE_F4: cok = cls.cont_f4;
            default: cok = cls.cont_normal;
        endcase

        if (active)
        begin
            used_next = ut0;
            if (!cls.empty_item)
            begin
                if (count_reg == '1)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
                if (pend_reg != 2'd0)
                begin
                    rule_next = RULE_NORMAL;
                    if (cok)
                    begin
                        pend_next = pend_reg - 2'd1;
                    end
                    else
                    begin
                        bad = 1'b1;
                        pend_next = 2'd0;
                    end
                end
                else if (cls.ascii)
                begin
                    pend_next = 2'd0;
                end
                else if (cls.lead2)
                begin
                    pend_next = 2'd1;
                    rule_next = RULE_NORMAL;
                end
                else if (cls.lead3)
                begin
                    pend_next = 2'd2;
                    rule_next = cls.lead_rule;
                end
                else if (cls.lead4)
                begin
                    pend_next = 2'd3;
                    rule_next = cls.lead_rule;
                end
                else
                begin
                    bad = 1'b1;
                end
                if (cls.forbidden)
                begin
                    byte_err = ERR_FORBIDDEN;
                end
                else if (bad)
                begin
                    byte_err = ERR_ENCODING;
                end
                if (ferr_reg == ERR_NONE)
                begin
                    ferr_next = byte_err;
                end
            end
        end

        cnt_w = CW'(count_next);
        sum = (CW + 1)'(ut0) + (CW + 1)'(count_next);
        if (count_next == '0)
        begin
            code = cfg.rej_empty ? ERR_EMPTY : ERR_NONE;
        end
        else if (ovf_next || (cnt_w > CW'(cfg.max_bytes)))
        begin
            code = ERR_TOO_LONG;
        end
        else if (ferr_next != ERR_NONE)
        begin
            code = ferr_next;
        end
        else if (pend_next != 2'd0)
        begin
            code = ERR_TRUNCATED;
        end
        else if (sum > (CW + 1)'(cfg.budget))
        begin
            code = ERR_BUDGET;
        end

        result.ok = (code == ERR_NONE);
        result.code = code;
        result.length = (cnt_w > CW'(16'hFFFF)) ? 16'hFFFF : cnt_w[15:0];
        result.budget_used = (code == ERR_NONE) ? sum[15:0] : ut0;

        if (out_push)
        begin
            used_next = result.budget_used;
            pend_next = 2'd0;
            rule_next = RULE_NORMAL;
            count_next = '0;
            ovf_next = 1'b0;
            ferr_next = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            rule_reg <= RULE_NORMAL;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            ferr_reg <= ERR_NONE;
            used_reg <= 16'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            rule_reg <= rule_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            ferr_reg <= ferr_next;
            used_reg <= used_next;
        end
    end

endmodule

@@ sv/strict_utf8_string_validator.sv @@
// Top level of the strict UTF-8 string validator.
// A byte request passes through the input queue to the back end, and the verdict of a string
// that it ends is written into the output queue, from which it is shown on the result ports.
// The back end takes one byte per cycle, except that a byte that ends a string waits while the output queue is full.
// Reset clears both queues, the string state and the byte budget, and loads the register
// defaults.
module strict_utf8_string_validator
    import usv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_string,
    input  logic                      empty_string,
    input  logic                      clear_budget,
    output logic                      empty,
    input  logic                      pop,
    output logic                      string_ok,
    output logic [2:0]                error_code,
    output logic [15:0]               string_length,
    output logic [15:0]               budget_used,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    class_t  cls_in;
    class_t  cls_q;
    logic    mid_empty;
    logic    mid_pop;
    logic    out_full;
    logic    out_push;
    result_t res_in;
    result_t res_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_bytes <= RESET_MAX_STRING_BYTES;
            cfg_reg.budget <= RESET_BUDGET_TOTAL;
            cfg_reg.rej_empty <= 1'b1;
            cfg_reg.rej_nul <= 1'b1;
            cfg_reg.rej_ctrl <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_STRING_BYTES: cfg_reg.max_bytes <= cfg_data;
                CFG_BUDGET_TOTAL:     cfg_reg.budget <= cfg_data;
                CFG_REJECT_EMPTY:     cfg_reg.rej_empty <= cfg_data[0];
                CFG_REJECT_NUL:       cfg_reg.rej_nul <= cfg_data[0];
                CFG_REJECT_CONTROL:   cfg_reg.rej_ctrl <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    usv_front u_front (
        .rej_nul       (cfg_reg.rej_nul),
        .rej_ctrl      (cfg_reg.rej_ctrl),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .empty_string  (empty_string),
        .clear_budget  (clear_budget),
        .cls           (cls_in)
    );

    usv_queue #(
        .WIDTH ($bits(class_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_in),
        .rd_en   (mid_pop),
        .rd_data (cls_q),
        .full    (full),
        .empty   (mid_empty)
    );

    usv_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cls      (cls_q),
        .in_empty (mid_empty),
        .in_pop   (mid_pop),
        .out_full (out_full),
        .out_push (out_push),
        .result   (res_in)
    );

    usv_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_q),
        .full    (out_full),
        .empty   (empty)
    );

    assign string_ok = res_q.ok;
    assign error_code = res_q.code;
    assign string_length = res_q.length;
    assign budget_used = res_q.budget_used;

endmodule

@@ tb/usv_verdict_checker.sv @@
// Checker that predicts each string verdict of the UTF-8 validator and compares it.
module usv_verdict_checker
    import usv_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic                      full,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_string,
    input  logic                      empty_string,
    input  logic                      clear_budget,
    input  logic                      empty,
    input  logic                      pop,
    input  logic                      string_ok,
    input  logic [2:0]                error_code,
    input  logic [15:0]               string_length,
    input  logic [15:0]               budget_used,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        mismatches,
    output int                        verdicts_waiting,
    output int                        verdicts_checked,
    output logic [6:0]                codes_seen
);

    cfg_t        regs;
    logic [1:0]  cont_left;
    rule_t       cont_rule;
    logic [15:0] byte_count;
    logic        count_full;
    err_t        first_err;
    logic [15:0] used_total;
    int          errs;
    int          checked;
    logic [6:0]  seen;
    result_t     verdicts_due[$];

    function automatic logic cont_fits(logic [7:0] b, rule_t which);
        case (which)
            RULE_E0: return b >= 8'hA0 && b <= 8'hBF;
            RULE_ED: return b >= 8'h80 && b <= 8'h9F;
            RULE_F0: return b >= 8'h90 && b <= 8'hBF;
            RULE_F4: return b >= 8'h80 && b <= 8'h8F;
            default: return b >= 8'h80 && b <= 8'hBF;
        endcase
    endfunction

    task automatic clear_string();
        cont_left = '0;
        cont_rule = RULE_NORMAL;
        byte_count = '0;
        count_full = 1'b0;
        first_err = ERR_NONE;
    endtask

    task automatic absorb_request(input logic [7:0] b, input logic eos, input logic emp,
                                  input logic clr);
        logic    forbidden;
        logic    bad;
        err_t    code;
        result_t verdict;
        if (clr)
            used_total = '0;
        if (!emp)
        begin
            if (byte_count == 16'hFFFF)
                count_full = 1'b1;
            else
                byte_count = byte_count + 16'd1;
            forbidden = (regs.rej_nul && b == 8'h00) ||
                        (regs.rej_ctrl && (b < 8'h20 || b == 8'h7F));
            bad = 1'b0;
            if (cont_left != 2'd0)
            begin
                if (cont_fits(b, cont_rule))
                    cont_left = cont_left - 2'd1;
                else
                begin
                    bad = 1'b1;
                    cont_left = 2'd0;
                end
                cont_rule = RULE_NORMAL;
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                cont_left = 2'd1;
                cont_rule = RULE_NORMAL;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                cont_left = 2'd2;
                cont_rule = (b == 8'hE0) ? RULE_E0 : (b == 8'hED) ? RULE_ED : RULE_NORMAL;
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                cont_left = 2'd3;
                cont_rule = (b == 8'hF0) ? RULE_F0 : (b == 8'hF4) ? RULE_F4 : RULE_NORMAL;
            end
            else if (b >= 8'h80)
                bad = 1'b1;
            if (first_err == ERR_NONE)
                first_err = forbidden ? ERR_FORBIDDEN : bad ? ERR_ENCODING : ERR_NONE;
            if (!eos)
                return;
        end
        if (byte_count == 16'd0)
            code = regs.rej_empty ? ERR_EMPTY : ERR_NONE;
        else if (count_full || byte_count > regs.max_bytes)
            code = ERR_TOO_LONG;
        else if (first_err != ERR_NONE)
            code = first_err;
        else if (cont_left != 2'd0)
            code = ERR_TRUNCATED;
        else if ((17'(used_total) + 17'(byte_count)) > 17'(regs.budget))
            code = ERR_BUDGET;
        else
            code = ERR_NONE;
        if (code == ERR_NONE)
            used_total = used_total + byte_count;
        verdict.ok = (code == ERR_NONE);
        verdict.code = code;
        verdict.length = byte_count;
        verdict.budget_used = used_total;
        verdicts_due.push_back(verdict);
        clear_string();
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            regs.max_bytes = RESET_MAX_STRING_BYTES;
            regs.budget = RESET_BUDGET_TOTAL;
            regs.rej_empty = 1'b1;
            regs.rej_nul = 1'b1;
            regs.rej_ctrl = 1'b0;
            used_total = '0;
            clear_string();
            verdicts_due.delete();
            errs = 0;
            checked = 0;
            seen = '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MAX_STRING_BYTES: regs.max_bytes = cfg_data;
                    CFG_BUDGET_TOTAL: regs.budget = cfg_data;
                    CFG_REJECT_EMPTY: regs.rej_empty = cfg_data[0];
                    CFG_REJECT_NUL: regs.rej_nul = cfg_data[0];
                    CFG_REJECT_CONTROL: regs.rej_ctrl = cfg_data[0];
                    default: ;
                endcase
            end
            if (push && !full)
                absorb_request(data_byte, end_of_string, empty_string, clear_budget);
            if (pop && !empty)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: verdict with none expected: ok %0b code %0d length %0d used %0d",
                             $time, string_ok, error_code, string_length, budget_used);
                    errs++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    check_field("string_ok", 16'(want.ok), 16'(string_ok));
                    check_field("error_code", 16'(want.code), 16'(error_code));
                    check_field("string_length", want.length, string_length);
                    check_field("budget_used", want.budget_used, budget_used);
                    checked++;
                end
                seen[error_code] = 1'b1;
            end
        end
        mismatches <= errs;
        verdicts_waiting <= verdicts_due.size();
        verdicts_checked <= checked;
        codes_seen <= seen;
    end

endmodule

@@ tb/strict_utf8_string_validator_tb.sv @@
// Testbench top for the strict UTF-8 string validator: stimulus, reset and verdict.
module strict_utf8_string_validator_tb;
    import usv_pkg::*;

    localparam int STALL_MAX = 14;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASES = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic [7:0]                data_byte;
    logic                      end_of_string;
    logic                      empty_string;
    logic                      clear_budget;
    logic                      empty;
    logic                      pop;
    logic                      string_ok;
    logic [2:0]                error_code;
    logic [15:0]               string_length;
    logic [15:0]               budget_used;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    int         mismatches;
    int         verdicts_waiting;
    int         verdicts_checked;
    logic [6:0] codes_seen;

    int         items_sent = 0;
    int         idle_cycles = 0;
    logic       send_steady = 1'b0;
    logic       take_steady = 1'b0;
    logic [7:0] text_bytes[$];

    strict_utf8_string_validator u_top (.*);

    usv_verdict_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("strict_utf8_string_validator_tb: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : take_results
        int stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(39, 0) == 0)
                take_steady = !take_steady;
            stall = take_steady ? 0 : $urandom_range(STALL_MAX, 0);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    function automatic logic draw_clear(input int odds);
        return (odds != 0) && ($urandom_range(odds - 1, 0) == 0);
    endfunction

    task automatic send_request(input logic [7:0] b, input logic eos, input logic emp,
                                input logic clr);
        int gap;
        gap = send_steady ? 0 : $urandom_range(STALL_MAX, 0);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        end_of_string <= eos;
        empty_string <= emp;
        clear_budget <= clr;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    // The sender holds off until every verdict has come back, then lets any byte
    // request that ends no string work its way through.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (verdicts_waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] max_len, input logic [15:0] total,
                                 input logic no_empty, input logic no_nul,
                                 input logic no_ctrl);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MAX_STRING_BYTES;
        cfg_data <= max_len;
        @(posedge clk);
        cfg_index <= CFG_BUDGET_TOTAL;
        cfg_data <= total;
        @(posedge clk);
        cfg_index <= CFG_REJECT_EMPTY;
        cfg_data <= {15'($urandom), no_empty};
        @(posedge clk);
        cfg_index <= CFG_REJECT_NUL;
        cfg_data <= {15'($urandom), no_nul};
        @(posedge clk);
        cfg_index <= CFG_REJECT_CONTROL;
        cfg_data <= {15'($urandom), no_ctrl};
        @(posedge clk);
        cfg_index <= CFG_UNUSED_INDEX;
        cfg_data <= 16'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_text(input logic close_with_empty, input int clear_odds);
        int   i;
        logic last;
        if (text_bytes.size() == 0)
        begin
            send_request(8'($urandom), 1'($urandom), 1'b1, draw_clear(clear_odds));
            return;
        end
        for (i = 0; i < text_bytes.size(); i++)
        begin
            last = (i == text_bytes.size() - 1) && !close_with_empty;
            send_request(text_bytes[i], last, 1'b0, draw_clear(clear_odds));
        end
        if (close_with_empty)
            send_request(8'($urandom), 1'($urandom), 1'b1, draw_clear(clear_odds));
    endtask

    task automatic add_char();
        int         kind;
        logic [7:0] lead;
        kind = $urandom_range(7, 0);
        if (kind < 4)
            text_bytes.push_back(($urandom_range(7, 0) == 0) ? 8'($urandom_range(32, 0))
                                                             : 8'($urandom_range(127, 32)));
        else if (kind == 4)
        begin
            text_bytes.push_back(8'($urandom_range(8'hDF, 8'hC2)));
            text_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
        else if (kind == 5)
        begin
            if ($urandom_range(1, 0) == 0)
                lead = ($urandom_range(1, 0) == 0) ? 8'hE0 : 8'hED;
            else
                lead = 8'($urandom_range(8'hEF, 8'hE0));
            text_bytes.push_back(lead);
            if (lead == 8'hE0)
                text_bytes.push_back(8'($urandom_range(8'hBF, 8'hA0)));
            else if (lead == 8'hED)
                text_bytes.push_back(8'($urandom_range(8'h9F, 8'h80)));
            else
                text_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            text_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
        else
        begin
            if ($urandom_range(1, 0) == 0)
                lead = ($urandom_range(1, 0) == 0) ? 8'hF0 : 8'hF4;
            else
                lead = 8'($urandom_range(8'hF4, 8'hF0));
            text_bytes.push_back(lead);
            if (lead == 8'hF0)
                text_bytes.push_back(8'($urandom_range(8'hBF, 8'h90)));
            else if (lead == 8'hF4)
                text_bytes.push_back(8'($urandom_range(8'h8F, 8'h80)));
            else
                text_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            text_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            text_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
    endtask

    // Mostly well-formed text with random content; a share is empty, cut short, corrupted,
    // padded with a stray byte from 80 to FF hex, or plain noise.
    task automatic compose_text(output logic close_with_empty);
        int shape;
        int chars;
        int i;
        text_bytes = {};
        close_with_empty = 1'b0;
        shape = $urandom_range(19, 0);
        if (shape == 0)
            return;
        if (shape == 1)
        begin
            chars = $urandom_range(5, 1);
            for (i = 0; i < chars; i++)
                text_bytes.push_back(8'($urandom));
            return;
        end
        chars = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 1);
        for (i = 0; i < chars; i++)
            add_char();
        if (shape == 2)
            void'(text_bytes.pop_back());
        else if (shape == 3)
            text_bytes[$urandom_range(text_bytes.size() - 1, 0)] = 8'($urandom);
        else if (shape == 4)
            text_bytes.insert($urandom_range(text_bytes.size(), 0),
                              8'($urandom_range(8'hFF, 8'h80)));
        close_with_empty = ($urandom_range(9, 0) == 0);
    endtask

    initial
    begin : stimulus
        logic close_end;
        int   p;
        int   phase_end;
        rst_n <= 1'b0;
        push <= 1'b0;
        data_byte <= '0;
        end_of_string <= 1'b0;
        empty_string <= 1'b0;
        clear_budget <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        text_bytes = {};
        send_text(1'b0, 1);
        text_bytes = '{8'h41};
        send_text(1'b0, 0);
        text_bytes = '{8'h00};
        send_text(1'b0, 0);
        // A NUL where a continuation byte belongs is both forbidden and badly encoded.
        text_bytes = '{8'hC2, 8'h00};
        send_text(1'b0, 0);
        text_bytes = '{8'hC0, 8'h80};
        send_text(1'b0, 0);
        text_bytes = '{8'hE0, 8'h9F};
        send_text(1'b0, 0);
        text_bytes = '{8'hED, 8'hA0};
        send_text(1'b0, 0);
        text_bytes = '{8'hF0, 8'h8F};
        send_text(1'b0, 0);
        text_bytes = '{8'hF4, 8'h90};
        send_text(1'b0, 0);
        text_bytes = '{8'hFF};
        send_text(1'b0, 0);
        text_bytes = '{8'h80};
        send_text(1'b0, 0);
        text_bytes = '{8'hE2};
        send_text(1'b1, 0);
        text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text(1'b0, 0);

        for (p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0: load_settings(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
                1: load_settings(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
                2: load_settings(16'h0001, 16'd100, 1'b0, 1'b1, 1'b0);
                default: load_settings(16'($urandom_range(24, 2)), 16'($urandom_range(300, 0)),
                                       1'($urandom), 1'($urandom), 1'($urandom));
            endcase
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(39, 0) == 0)
                    send_steady = !send_steady;
                compose_text(close_end);
                send_text(close_end, (p % 2 == 0) ? 25 : 0);
                if ($urandom_range(49, 0) == 0)
                    wait_idle();
            end
        end
        wait_idle();

        $display("Sent %0d requests over %0d register settings.",
                 items_sent, PHASES + 1);
        $display("Checked %0d verdicts; error codes returned, one bit per code: %b.",
                 verdicts_checked, codes_seen);
        if (mismatches == 0)
            $display("strict_utf8_string_validator_tb: PASS");
        else
            $display("strict_utf8_string_validator_tb: FAIL");
        $finish;
    end

endmodule
